### rtl/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers of the buddy block allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // fixed field widths
    localparam int ADDR_W = 64;
    localparam int SIZE_W = 32;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int CLS_W  = 5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM       = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR  = 2'd3;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // write enables of the unit table
    typedef struct packed {
        logic cls;
        logic lst;
        logic nxt;
        logic prv;
    } t_mem_we;

    // smallest b with 2^b >= v, zero for v of zero or one
    function automatic logic [5:0] bba_clog2(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] m;
        logic [5:0]        r;
        m = v - SIZE_W'(1);
        r = '0;
        if (v > SIZE_W'(1)) begin
            for (int i = 0; i < SIZE_W; i++) begin
                if (m[i]) begin
                    r = 6'(i + 1);
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/bba_ifs.sv
// ---------------------------------------------------------------------------
// bba request and response channels
// Valid/ready channels carrying one request beat and one result beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bba_req_if import bba_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] device_address;

    modport source (output valid, mode, size_bytes, device_address, input ready);
    modport sink   (input valid, mode, size_bytes, device_address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  blocks_in_use;

    modport source (output valid, status, block_address, blocks_in_use, input ready);
    modport sink   (input valid, status, block_address, blocks_in_use, output ready);
endinterface

`default_nettype wire

### rtl/bba_unit_mem.sv
// ---------------------------------------------------------------------------
// bba_unit_mem
// Per-unit table: size class, listed flag and free list links, one read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bba_unit_mem import bba_pkg::*; #(
    parameter int TOP = 10
) (
    input  wire logic             i_clk,
    input  wire t_mem_we          i_we,
    input  wire logic [TOP-1:0]   i_cls_addr,
    input  wire logic [CLS_W-1:0] i_cls_data,
    input  wire logic [TOP-1:0]   i_lst_addr,
    input  wire logic             i_lst_data,
    input  wire logic [TOP-1:0]   i_nxt_addr,
    input  wire logic [TOP:0]     i_nxt_data,
    input  wire logic [TOP-1:0]   i_prv_addr,
    input  wire logic [TOP:0]     i_prv_data,
    input  wire logic [TOP-1:0]   i_rd_addr,
    output logic      [CLS_W-1:0] o_cls,
    output logic                  o_lst,
    output logic      [TOP:0]     o_nxt,
    output logic      [TOP:0]     o_prv
);

    localparam int NUM = 1 << TOP;

    logic [CLS_W-1:0] r_cls_mem [NUM];
    logic             r_lst_mem [NUM];
    logic [TOP:0]     r_nxt_mem [NUM];
    logic [TOP:0]     r_prv_mem [NUM];

    // writes
    always_ff @(posedge i_clk) begin
        if (i_we.cls) begin
            r_cls_mem[i_cls_addr] <= i_cls_data;
        end
        if (i_we.lst) begin
            r_lst_mem[i_lst_addr] <= i_lst_data;
        end
        if (i_we.nxt) begin
            r_nxt_mem[i_nxt_addr] <= i_nxt_data;
        end
        if (i_we.prv) begin
            r_prv_mem[i_prv_addr] <= i_prv_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_cls <= r_cls_mem[i_rd_addr];
        o_lst <= r_lst_mem[i_rd_addr];
        o_nxt <= r_nxt_mem[i_rd_addr];
        o_prv <= r_prv_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/buddy_block_allocator.sv
// ---------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over one segment of power-of-two units, run by a sequencer.
// ---------------------------------------------------------------------------
// After reset the block sweeps all 2^(SEGMENT_BITS-UNIT_BITS) units of its
// unit table, one unit a cycle, and takes no request until done. Each
// request is then handled alone by a sequencer around one unit table with a
// single read port. An allocate walks up the classes to the first non-empty
// one and splits the block found down to the requested class; a free merges
// the block with free buddies up the classes. These split and merge walks
// over the table set how long a request takes. Rejected requests finish sooner.
// ---------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator import bba_pkg::*; #(
    parameter int UNIT_BITS    = 12,
    parameter int SEGMENT_BITS = 22
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    bba_req_if.sink                i_req,
    bba_rsp_if.source              o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_wdata
);

    localparam int TOP  = SEGMENT_BITS - UNIT_BITS;
    localparam int UW   = TOP;
    localparam int TB   = TOP + 1;
    localparam int NUM  = 1 << TOP;
    localparam int NCLS = TOP + 1;
    localparam int CIW  = $clog2(NCLS);
    localparam int CW   = CIW + 1;
    localparam logic [TB-1:0] NIL = TB'(NUM);

    // sequencer states
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_A_SIZE = 5'd2;
    localparam logic [4:0] S_A_SRCH = 5'd3;
    localparam logic [4:0] S_UL_RD  = 5'd4;
    localparam logic [4:0] S_UL_W1  = 5'd5;
    localparam logic [4:0] S_UL_W2  = 5'd6;
    localparam logic [4:0] S_PT1    = 5'd7;
    localparam logic [4:0] S_PT2    = 5'd8;
    localparam logic [4:0] S_F_CHK  = 5'd9;
    localparam logic [4:0] S_F_RDU  = 5'd10;
    localparam logic [4:0] S_F_BUD  = 5'd11;
    localparam logic [4:0] S_F_BCHK = 5'd12;
    localparam logic [4:0] S_PH1    = 5'd13;
    localparam logic [4:0] S_PH2    = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    logic [4:0]        r_state, n_state;
    logic [UW-1:0]     r_clr, n_clr;
    logic              r_mode, n_mode;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [ADDR_W-1:0] r_dev, n_dev;
    logic [ADDR_W-1:0] r_base;
    logic [TB-1:0]     r_head [NCLS];
    logic [TB-1:0]     n_head [NCLS];
    logic [TB-1:0]     r_tail [NCLS];
    logic [TB-1:0]     n_tail [NCLS];
    logic [TB-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_c, n_c;
    logic [CW-1:0]     r_k, n_k;
    logic [UW-1:0]     r_x, n_x;
    logic [UW-1:0]     r_u, n_u;
    logic [UW-1:0]     r_w, n_w;
    logic              r_hi, n_hi;
    logic [STAT_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0] r_blk, n_blk;

    // unit table ports
    t_mem_we          mem_we;
    logic [UW-1:0]    cls_addr, lst_addr, nxt_addr, prv_addr, rd_addr;
    logic [CLS_W-1:0] cls_data, rd_cls;
    logic             lst_data, rd_lst;
    logic [TB-1:0]    nxt_data, prv_data, rd_nxt, rd_prv;

    // helpers
    logic [5:0]        size_b;
    logic [CW-1:0]     d_c;
    logic [CIW-1:0]    c_idx, d_idx;
    logic [ADDR_W-1:0] off;
    logic              bad_addr;
    logic [UW-1:0]     off_unit;

    bba_unit_mem #(.TOP(TOP)) u_mem (
        .i_clk      (i_clk),
        .i_we       (mem_we),
        .i_cls_addr (cls_addr),
        .i_cls_data (cls_data),
        .i_lst_addr (lst_addr),
        .i_lst_data (lst_data),
        .i_nxt_addr (nxt_addr),
        .i_nxt_data (nxt_data),
        .i_prv_addr (prv_addr),
        .i_prv_data (prv_data),
        .i_rd_addr  (rd_addr),
        .o_cls      (rd_cls),
        .o_lst      (rd_lst),
        .o_nxt      (rd_nxt),
        .o_prv      (rd_prv)
    );

    // request decode helpers
    assign size_b   = bba_clog2(r_size);
    assign d_c      = r_c - CW'(1);
    assign c_idx    = r_c[CIW-1:0];
    assign d_idx    = d_c[CIW-1:0];
    assign off      = r_dev - r_base;
    assign bad_addr = (r_dev < r_base) || ((off >> SEGMENT_BITS) != '0)
                      || (off[UNIT_BITS-1:0] != '0);
    assign off_unit = off[UNIT_BITS +: UW];

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_mode   = r_mode;
        n_size   = r_size;
        n_dev    = r_dev;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_c      = r_c;
        n_k      = r_k;
        n_x      = r_x;
        n_u      = r_u;
        n_w      = r_w;
        n_hi     = r_hi;
        n_status = r_status;
        n_blk    = r_blk;
        mem_we   = '0;
        cls_addr = r_x;
        lst_addr = r_x;
        nxt_addr = r_x;
        prv_addr = r_x;
        cls_data = '0;
        lst_data = 1'b0;
        nxt_data = NIL;
        prv_data = NIL;
        rd_addr  = r_x;

        unique case (r_state)
            // table sweep after reset
            S_CLR: begin
                mem_we   = '1;
                cls_addr = r_clr;
                lst_addr = r_clr;
                nxt_addr = r_clr;
                prv_addr = r_clr;
                cls_data = (r_clr == '0) ? CLS_W'(TOP) : '0;
                lst_data = (r_clr == '0);
                n_clr    = r_clr + UW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_size  = i_req.size_bytes;
                    n_dev   = i_req.device_address;
                    n_state = (i_req.mode == MODE_FREE) ? S_F_CHK : S_A_SIZE;
                end
            end
            // size class of the request
            S_A_SIZE: begin
                if (size_b > 6'(SEGMENT_BITS)) begin
                    n_status = ST_TOO_LARGE;
                    n_blk    = '0;
                    n_state  = S_OUT;
                end else begin
                    n_k     = (size_b > 6'(UNIT_BITS)) ? CW'(size_b - 6'(UNIT_BITS)) : '0;
                    n_c     = (size_b > 6'(UNIT_BITS)) ? CW'(size_b - 6'(UNIT_BITS)) : '0;
                    n_state = S_A_SRCH;
                end
            end
            // walk up to the first non-empty class
            S_A_SRCH: begin
                if (r_c > CW'(TOP)) begin
                    n_status = ST_OOM;
                    n_blk    = '0;
                    n_state  = S_OUT;
                end else if (r_head[c_idx] == NIL) begin
                    n_c = r_c + CW'(1);
                end else begin
                    n_x     = r_head[c_idx][UW-1:0];
                    n_state = S_UL_RD;
                end
            end
            S_UL_RD: begin
                rd_addr = r_x;
                n_state = S_UL_W1;
            end
            // unlink: patch the neighbors
            S_UL_W1: begin
                if (rd_prv != NIL) begin
                    mem_we.nxt = 1'b1;
                    nxt_addr   = rd_prv[UW-1:0];
                    nxt_data   = rd_nxt;
                end else begin
                    n_head[c_idx] = rd_nxt;
                end
                if (rd_nxt != NIL) begin
                    mem_we.prv = 1'b1;
                    prv_addr   = rd_nxt[UW-1:0];
                    prv_data   = rd_prv;
                end else begin
                    n_tail[c_idx] = rd_prv;
                end
                n_state = S_UL_W2;
            end
            // unlink: clear the unit, then continue by mode
            S_UL_W2: begin
                mem_we.nxt = 1'b1;
                mem_we.prv = 1'b1;
                mem_we.lst = 1'b1;
                if (r_mode == MODE_FREE) begin
                    mem_we.cls = 1'b1;
                    cls_addr   = (r_x > r_u) ? r_x : r_u;
                    n_u        = (r_x < r_u) ? r_x : r_u;
                    n_c        = r_c + CW'(1);
                    n_state    = S_F_BUD;
                end else if (r_c == r_k) begin
                    mem_we.cls = 1'b1;
                    cls_data   = CLS_W'(r_k);
                    if (r_cnt < TB'(NUM)) begin
                        n_cnt = r_cnt + TB'(1);
                    end
                    n_status = ST_OK;
                    n_blk    = r_base + (ADDR_W'(r_x) << UNIT_BITS);
                    n_state  = S_OUT;
                end else begin
                    n_w     = r_x;
                    n_hi    = 1'b0;
                    n_state = S_PT1;
                end
            end
            // push a half to the tail of the lower class
            S_PT1: begin
                mem_we   = '1;
                cls_addr = r_w;
                lst_addr = r_w;
                nxt_addr = r_w;
                prv_addr = r_w;
                cls_data = CLS_W'(d_c);
                lst_data = 1'b1;
                prv_data = r_tail[d_idx];
                n_state  = S_PT2;
            end
            S_PT2: begin
                if (r_tail[d_idx] != NIL) begin
                    mem_we.nxt = 1'b1;
                    nxt_addr   = r_tail[d_idx][UW-1:0];
                    nxt_data   = TB'(r_w);
                end else begin
                    n_head[d_idx] = TB'(r_w);
                end
                n_tail[d_idx] = TB'(r_w);
                if (!r_hi) begin
                    n_hi    = 1'b1;
                    n_w     = r_w | (UW'(1) << d_c);
                    n_state = S_PT1;
                end else begin
                    n_c     = d_c;
                    n_x     = r_head[d_idx][UW-1:0];
                    n_state = S_UL_RD;
                end
            end
            // free: range and alignment check, read the unit
            S_F_CHK: begin
                if (bad_addr) begin
                    n_status = ST_BAD_ADDR;
                    n_blk    = '0;
                    n_state  = S_OUT;
                end else begin
                    rd_addr = off_unit;
                    n_u     = off_unit;
                    n_state = S_F_RDU;
                end
            end
            S_F_RDU: begin
                if (rd_lst) begin
                    n_status = ST_BAD_ADDR;
                    n_blk    = '0;
                    n_state  = S_OUT;
                end else begin
                    n_c     = (rd_cls > CLS_W'(TOP)) ? CW'(TOP) : CW'(rd_cls);
                    n_state = S_F_BUD;
                end
            end
            // read the buddy of the current block
            S_F_BUD: begin
                if (r_c == CW'(TOP)) begin
                    n_state = S_PH1;
                end else begin
                    n_x     = r_u ^ (UW'(1) << r_c);
                    rd_addr = r_u ^ (UW'(1) << r_c);
                    n_state = S_F_BCHK;
                end
            end
            S_F_BCHK: begin
                if (!rd_lst || (rd_cls != CLS_W'(r_c))) begin
                    n_state = S_PH1;
                end else begin
                    n_state = S_UL_W1;
                end
            end
            // push the merged block to its class head
            S_PH1: begin
                mem_we   = '1;
                cls_addr = r_u;
                lst_addr = r_u;
                nxt_addr = r_u;
                prv_addr = r_u;
                cls_data = CLS_W'(r_c);
                lst_data = 1'b1;
                nxt_data = r_head[c_idx];
                n_state  = S_PH2;
            end
            S_PH2: begin
                if (r_head[c_idx] != NIL) begin
                    mem_we.prv = 1'b1;
                    prv_addr   = r_head[c_idx][UW-1:0];
                    prv_data   = TB'(r_u);
                end else begin
                    n_tail[c_idx] = TB'(r_u);
                end
                n_head[c_idx] = TB'(r_u);
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - TB'(1);
                end
                n_status = ST_OK;
                n_blk    = '0;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < NCLS; i++) begin
                r_head[i] <= (i == TOP) ? TB'(0) : NIL;
                r_tail[i] <= (i == TOP) ? TB'(0) : NIL;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_size   <= n_size;
        r_dev    <= n_dev;
        r_c      <= n_c;
        r_k      <= n_k;
        r_x      <= n_x;
        r_u      <= n_u;
        r_w      <= n_w;
        r_hi     <= n_hi;
        r_status <= n_status;
        r_blk    <= n_blk;
    end

    // segment base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // channel outputs
    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.status        = r_status;
    assign o_rsp.block_address = r_blk;
    assign o_rsp.blocks_in_use = CNT_W'(r_cnt);

`ifndef ASSERT_OFF
    // never takes a request while a result beat is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request taken while result pending");

    // block count moves only as a result is posted
    a_cnt_at_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cnt) |-> (r_state == S_OUT))
        else $error("block count changed outside result");

    // a granted block is unit aligned within the segment
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (r_mode == MODE_ALLOC) && (o_rsp.status == ST_OK))
        |-> (((o_rsp.block_address - r_base) & ((ADDR_W'(1) << UNIT_BITS) - ADDR_W'(1)))
             == '0))
        else $error("granted block misaligned");

    // no request during the table sweep
    a_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (!i_req.ready && !o_rsp.valid))
        else $error("channel active during table sweep");
`endif

endmodule

`default_nettype wire
